FILE: src/lhst_pkg.sv
// lhst_pkg: shared types and constants of the hot set tracker
// no dependencies; used by lhst_cell and lru_hot_set_tracker

package lhst_pkg;

    // field widths
    localparam int ARCHIVE_W = 16;
    localparam int COUNT_W   = 17;
    localparam int BUDGET_W  = 5;
    localparam int STATUS_W  = 2;

    // default list capacity
    localparam int DEF_LIST_DEPTH = 16;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_HIT   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // register map: index = byte address / 4
    localparam int REG_IDX_W = 1;
    localparam int APB_ADDR_W = REG_IDX_W + 2;
    localparam logic [REG_IDX_W-1:0] REG_ARCHIVE_COUNT = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_HOT_BUDGET    = 1'd1;

    // reset values of the registers
    localparam logic [COUNT_W-1:0]  RST_ARCHIVE_COUNT = 17'd0;
    localparam logic [BUDGET_W-1:0] RST_HOT_BUDGET    = 5'd16;

    // per-cell control from the sequencer
    typedef struct packed {
        logic compare;   // latch the match flag against the key
        logic shift;     // shift step of the list update
        logic in_list;   // cell holds a resident entry
        logic in_window; // cell lies within the shift window on a miss
    } cell_ctrl_t;

endpackage

FILE: src/lhst_cell.sv
// lhst_cell: one slot of the recency list, with its match flag
// depends on lhst_pkg

module lhst_cell import lhst_pkg::*; (
    input  logic                 aclk,
    input  cell_ctrl_t           ctrl,
    input  logic [ARCHIVE_W-1:0] key,
    input  logic [ARCHIVE_W-1:0] prev_value,
    input  logic                 seen_in,
    output logic [ARCHIVE_W-1:0] value,
    output logic                 seen_out
);

    logic [ARCHIVE_W-1:0] value_reg;
    logic                 match_reg;

    // compare on the compare step, take the neighbour's entry on the shift step
    always_ff @(posedge aclk) begin
        if (ctrl.compare) begin
            match_reg <= ctrl.in_list && (value_reg == key);
        end
        if (ctrl.shift && !seen_in && ctrl.in_window) begin
            value_reg <= prev_value;
        end
    end

    // a hit at or before this cell stops the shift further down
    assign seen_out = seen_in | match_reg;
    assign value    = value_reg;

endmodule

FILE: src/lru_hot_set_tracker.sv
// lru_hot_set_tracker: top level, sequencer, registers and output stage
// depends on lhst_pkg and lhst_cell

// Most-recently-used list of resident archives held in a row of
// LIST_DEPTH+1 cells; cell 0 is the most recent. A request is taken when
// s_ready is high, then compared against every cell in the compare state
// and the list shifted by one place in the shift state, before a hit, or
// a miss without eviction, enters the output register from the report
// state; a miss that evicts gives one victim per cycle from the back of
// the list while the output register is free. An out-of-range index gives
// its result from the compare state. The next request is taken the cycle
// after the final result enters the output register, while that result
// still waits on m_ready. The budget is saturated to LIST_DEPTH; lowering
// it takes effect on the next miss.

module lru_hot_set_tracker import lhst_pkg::*; #(
    parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [ARCHIVE_W-1:0]  s_archive_index,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic                  m_evicted,
    output logic [ARCHIVE_W-1:0]  m_victim_archive,
    output logic                  m_last,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int NCELLS = LIST_DEPTH + 1;
    localparam int LEN_W  = $clog2(LIST_DEPTH + 2);
    localparam int IDX_W  = $clog2(NCELLS);
    localparam int BW     = (LEN_W > BUDGET_W) ? LEN_W : BUDGET_W;
    localparam logic [BW-1:0] DEPTH_C = BW'(LIST_DEPTH);

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CMP    = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;
    localparam logic [1:0] S_REPORT = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [ARCHIVE_W-1:0] key_reg;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic                 hit_reg, hit_next;
    logic [COUNT_W-1:0]   archive_count_reg;
    logic [BUDGET_W-1:0]  hot_budget_reg;

    logic                  m_valid_reg;
    logic [STATUS_W-1:0]   m_status_reg;
    logic                  m_evicted_reg;
    logic [ARCHIVE_W-1:0]  m_victim_reg;
    logic                  m_last_reg;

    logic                  emit;
    logic [STATUS_W-1:0]   emit_status;
    logic                  emit_evicted;
    logic [ARCHIVE_W-1:0]  emit_victim;
    logic                  emit_last;

    logic                  out_free;
    logic                  out_of_range;
    logic [BW-1:0]         len_ext;
    logic [BW-1:0]         budget_ext;
    logic [BW-1:0]         budget_sat;
    logic [LEN_W-1:0]      len_dec;
    logic                  apb_write;

    logic [ARCHIVE_W-1:0]  cell_value [NCELLS];
    logic [ARCHIVE_W-1:0]  cell_prev  [NCELLS];
    logic [NCELLS:0]       seen;
    cell_ctrl_t            cell_ctrl  [NCELLS];

    // configuration registers
    assign apb_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            archive_count_reg <= RST_ARCHIVE_COUNT;
            hot_budget_reg    <= RST_HOT_BUDGET;
        end else if (apb_write) begin
            case (paddr[APB_ADDR_W-1:2])
                REG_ARCHIVE_COUNT: archive_count_reg <= pwdata[COUNT_W-1:0];
                REG_HOT_BUDGET:    hot_budget_reg    <= pwdata[BUDGET_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (paddr[APB_ADDR_W-1:2])
            REG_ARCHIVE_COUNT: prdata = {{(32-COUNT_W){1'b0}}, archive_count_reg};
            REG_HOT_BUDGET:    prdata = {{(32-BUDGET_W){1'b0}}, hot_budget_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // row of cells, each fed by its neighbour towards the front, cell 0 by the key
    assign seen[0] = 1'b0;

    for (genvar i = 0; i < NCELLS; i++) begin : g_cell
        if (i == 0) begin : g_front
            assign cell_prev[i] = key_reg;
        end else begin : g_rest
            assign cell_prev[i] = cell_value[i-1];
        end

        assign cell_ctrl[i].compare   = (state_reg == S_CMP);
        assign cell_ctrl[i].shift     = (state_reg == S_SHIFT);
        assign cell_ctrl[i].in_list   = (LEN_W'(i) < len_reg);
        assign cell_ctrl[i].in_window = (LEN_W'(i) <= len_reg);

        lhst_cell u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl[i]),
            .key        (key_reg),
            .prev_value (cell_prev[i]),
            .seen_in    (seen[i]),
            .value      (cell_value[i]),
            .seen_out   (seen[i+1])
        );
    end

    // range check, budget saturation and back-of-list position
    assign out_of_range = ({1'b0, key_reg} >= archive_count_reg);
    assign len_ext      = BW'(len_reg);
    assign budget_ext   = BW'(hot_budget_reg);
    assign budget_sat   = (budget_ext > DEPTH_C) ? DEPTH_C : budget_ext;
    assign len_dec      = len_reg - LEN_W'(1);
    assign out_free     = !m_valid_reg || m_ready;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        len_next     = len_reg;
        hit_next     = hit_reg;
        emit         = 1'b0;
        emit_status  = ST_HIT;
        emit_evicted = 1'b0;
        emit_victim  = '0;
        emit_last    = 1'b1;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (out_of_range) begin
                    if (out_free) begin
                        emit        = 1'b1;
                        emit_status = ST_RANGE;
                        state_next  = S_IDLE;
                    end
                end else begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT: begin
                hit_next   = seen[NCELLS];
                state_next = S_REPORT;
                if (!seen[NCELLS]) begin
                    len_next = len_reg + LEN_W'(1);
                end
            end
            S_REPORT: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (hit_reg) begin
                        emit_status = ST_HIT;
                        state_next  = S_IDLE;
                    end else if (len_ext > budget_sat) begin
                        emit_status  = ST_MISS;
                        emit_evicted = 1'b1;
                        emit_victim  = cell_value[len_dec[IDX_W-1:0]];
                        emit_last    = (len_ext <= budget_sat + BW'(1));
                        len_next     = len_dec;
                        if (len_ext <= budget_sat + BW'(1)) begin
                            state_next = S_IDLE;
                        end
                    end else begin
                        emit_status = ST_MISS;
                        state_next  = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            hit_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            hit_reg   <= hit_next;
        end
    end

    // request capture
    assign s_ready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            key_reg <= s_archive_index;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_status_reg  <= emit_status;
            m_evicted_reg <= emit_evicted;
            m_victim_reg  <= emit_victim;
            m_last_reg    <= emit_last;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_evicted        = m_evicted_reg;
    assign m_victim_archive = m_victim_reg;
    assign m_last           = m_last_reg;

`ifndef SYNTH
    // list never holds more than its capacity between requests
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (len_reg <= LEN_W'(LIST_DEPTH)))
        else $error("recency list longer than its capacity");

    // non-eviction results carry a zero victim and close the request
    a_no_victim: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_evicted) |-> (m_victim_archive == '0 && m_last))
        else $error("non-eviction result with victim or without last");

    // a hit never evicts and leaves the length unchanged
    a_hit_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT && seen[NCELLS]) |=> (len_reg == $past(len_reg)))
        else $error("hit changed the list length");

    // an out-of-range result is single and never an eviction
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_RANGE) |-> (m_last && !m_evicted))
        else $error("out-of-range result malformed");
`endif

endmodule
